// File: rtl/core/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg: shared constants and functions of the haversine distance core
// Field widths, fixed-point constants, CORDIC arctangent table, register codes.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int LAT_W      = 28;
    localparam int LON_W      = 29;
    localparam int RADIUS_W   = 24;
    localparam int DIST_W     = 26;
    localparam int CORDIC_W   = 34;
    localparam int UNIT_W     = 31;
    localparam int SQRT_STEPS = 31;
    localparam int SQ_VW      = 61;
    localparam int SQ_RW      = 62;
    localparam int ANG_W      = 32;

    localparam logic [UNIT_W-1:0]          ONE_Q30    = 31'h4000_0000;
    localparam logic signed [CORDIC_W-1:0] GAIN_INV   = 34'sd652032874;
    localparam logic [ANG_W-1:0]           PI_Q30     = 32'd3373259426;
    localparam logic [32:0]                DEG2RAD    = 33'd4797524517;
    localparam logic [RADIUS_W-1:0]        RADIUS_RST = 24'd6371000;

    localparam logic REG_RADIUS = 1'b0;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int unsigned idx);
        logic signed [CORDIC_W-1:0] t;
        case (idx)
            0: t = 34'sd843314856;
            1: t = 34'sd497837829;
            2: t = 34'sd263043836;
            3: t = 34'sd133525158;
            4: t = 34'sd67021686;
            5: t = 34'sd33543515;
            6: t = 34'sd16775850;
            7: t = 34'sd8388437;
            8: t = 34'sd4194282;
            9: t = 34'sd2097149;
            default:
            begin
                if (idx <= 30)
                begin
                    t = (CORDIC_W'(1) << (30 - idx)) - CORDIC_W'(1);
                end
                else
                begin
                    t = '0;
                end
            end
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/hvd_if.sv
// ----------------------------------------------------------------------------
// hvd_if: request and response channels of the haversine distance core
// Valid/ready channels carrying the point pair and the distance result.
// ----------------------------------------------------------------------------
interface hvd_req_if;
    import hvd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;

    modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                    input ready);
    modport sink   (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                    output ready);
endinterface

interface hvd_rsp_if;
    import hvd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_m;
    logic              range_error;

    modport source (output valid, output distance_m, output range_error, input ready);
    modport sink   (input valid, input distance_m, input range_error, output ready);
endinterface

// File: rtl/core/hvd_cordic.sv
// ----------------------------------------------------------------------------
// hvd_cordic: pipelined CORDIC, one micro-rotation per register stage
// Rotation mode steers by the sign of z, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module hvd_cordic #(
    parameter int ITER      = 32,
    parameter bit VECTORING = 1'b0
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hvd_pkg::CORDIC_W-1:0] x_in,
    input  logic signed [hvd_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [hvd_pkg::CORDIC_W-1:0] z_in,
    output logic signed [hvd_pkg::CORDIC_W-1:0] x_out,
    output logic signed [hvd_pkg::CORDIC_W-1:0] y_out,
    output logic signed [hvd_pkg::CORDIC_W-1:0] z_out
);
    import hvd_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [ITER];
    logic signed [CORDIC_W-1:0] y_reg [ITER];
    logic signed [CORDIC_W-1:0] z_reg [ITER];

    for (genvar i = 0; i < ITER; i++)
    begin : g_step
        logic signed [CORDIC_W-1:0] xp, yp, zp, dx, dy, t;
        logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
        logic                       fwd;

        if (i == 0)
        begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
        end
        else
        begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
        end

        assign dx  = yp >>> i;
        assign dy  = xp >>> i;
        assign t   = atan_q30(i);
        assign fwd = VECTORING ? !yp[CORDIC_W-1] : !zp[CORDIC_W-1];

        always_comb
        begin
            if (fwd != VECTORING)
            begin
                x_next = xp - dx;
                y_next = yp + dy;
            end
            else
            begin
                x_next = xp + dx;
                y_next = yp - dy;
            end
            if (fwd != VECTORING)
            begin
                z_next = zp - t;
            end
            else
            begin
                z_next = zp + t;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign x_out = x_reg[ITER-1];
    assign y_out = y_reg[ITER-1];
    assign z_out = z_reg[ITER-1];

endmodule

// File: rtl/core/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt: pipelined integer square root, one root bit per register stage
// Exact floor root of a value up to 2^60.
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  logic                              clk,
    input  logic                              en,
    input  logic [hvd_pkg::SQ_VW-1:0]         v_in,
    output logic [hvd_pkg::UNIT_W-1:0]        root
);
    import hvd_pkg::*;

    logic [SQ_VW-1:0] v_reg [SQRT_STEPS];
    logic [SQ_RW-1:0] r_reg [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        localparam logic [SQ_RW-1:0] BIT = SQ_RW'(1) << (2 * (SQRT_STEPS - 1 - s));
        logic [SQ_VW-1:0] vp, v_next;
        logic [SQ_RW-1:0] rp, r_next, trial;

        if (s == 0)
        begin : g_first
            assign vp = v_in;
            assign rp = '0;
        end
        else
        begin : g_rest
            assign vp = v_reg[s-1];
            assign rp = r_reg[s-1];
        end

        assign trial = rp + BIT;

        always_comb
        begin
            if (SQ_RW'(vp) >= trial)
            begin
                v_next = vp - trial[SQ_VW-1:0];
                r_next = (rp >> 1) + BIT;
            end
            else
            begin
                v_next = vp;
                r_next = rp >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s] <= v_next;
                r_reg[s] <= r_next;
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][UNIT_W-1:0];

endmodule

// File: rtl/core/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance between two points on a sphere
// Fully pipelined haversine core with an APB radius register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one point pair (latitudes and longitudes in signed degrees
//   with ANGLE_FRAC_BITS fraction bits); rsp returns the distance in whole
//   meters and a range flag. A pair with a latitude beyond 90 degrees or a
//   longitude beyond 180 degrees returns distance 0 with range_error set.
//   One request enters per cycle while req.ready is high. A request passes
//   through the two CORDIC pipelines of one stage per iteration and the
//   31-stage square root pipeline.
//   The whole pipeline advances together: while a result waits in the output
//   register and rsp.ready is low, every stage holds and req.ready is low.
//   Reset empties the pipeline and loads the radius register with 6371000.
//   Write sphere_radius_m at byte address 0 over APB only while idle.
// ----------------------------------------------------------------------------
module haversine_distance #(
    parameter int ANGLE_FRAC_BITS   = 20,
    parameter int CORDIC_ITERATIONS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hvd_req_if.sink     req,
    hvd_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hvd_pkg::*;

    localparam int N     = CORDIC_ITERATIONS;
    localparam int DEPTH = 2 * N + 38;
    localparam int SH_LAT  = ANGLE_FRAC_BITS + 8;
    localparam int SH_HALF = ANGLE_FRAC_BITS + 9;
    localparam logic [63:0] LAT_MAX  = 64'd90 << ANGLE_FRAC_BITS;
    localparam logic [63:0] LON_MAX  = 64'd180 << ANGLE_FRAC_BITS;
    localparam logic [65:0] RND_LAT  = 66'd1 << (SH_LAT - 1);
    localparam logic [65:0] RND_HALF = 66'd1 << (SH_HALF - 1);
    localparam logic [16:0] D_LO = DEG2RAD[16:0];
    localparam logic [15:0] D_HI = DEG2RAD[32:17];

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
        logic [UNIT_W-1:0] r;
        if (v[CORDIC_W-1])
        begin
            r = '0;
        end
        else if (v > $signed({1'b0, ONE_Q30}))
        begin
            r = ONE_Q30;
        end
        else
        begin
            r = UNIT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [UNIT_W-1:0] pmul(input logic [UNIT_W-1:0] u,
                                               input logic [UNIT_W-1:0] v);
        logic [2*UNIT_W-1:0] p;
        p = u * v + (2 * UNIT_W)'(1 << 29);
        return UNIT_W'(p >> 30);
    endfunction

    // configuration
    logic [RADIUS_W-1:0] radius_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS)
        begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    // pipeline control
    logic               en;
    logic               rsp_valid_reg;
    logic [DEPTH-1:0]   vld_reg;
    logic [DEPTH-1:0]   err_reg;

    assign en        = !rsp_valid_reg || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], req.valid};
            rsp_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    // input magnitudes and range check
    logic signed [31:0] la_x, lb_x, oa_x, ob_x;
    logic [31:0]        mag_in [4];
    logic [31:0]        dlon_raw;
    logic               err_in;

    assign la_x = 32'(req.lat_a);
    assign lb_x = 32'(req.lat_b);
    assign oa_x = 32'(req.lon_a);
    assign ob_x = 32'(req.lon_b);

    assign mag_in[0] = mag32(la_x);
    assign mag_in[1] = mag32(lb_x);
    assign mag_in[2] = mag32(lb_x - la_x);
    assign dlon_raw  = mag32(ob_x - oa_x);
    assign mag_in[3] = (64'(dlon_raw) > LON_MAX) ? 32'((LON_MAX << 1) - 64'(dlon_raw))
                                                 : dlon_raw;

    assign err_in = (64'(mag_in[0]) > LAT_MAX) || (64'(mag_in[1]) > LAT_MAX) ||
                    (64'(mag32(oa_x)) > LON_MAX) || (64'(mag32(ob_x)) > LON_MAX);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg <= {err_reg[DEPTH-2:0], err_in};
        end
    end

    // degrees to radians
    logic [31:0]                mag_reg    [4];
    logic [48:0]                rad_lo_reg [4];
    logic [47:0]                rad_hi_reg [4];
    logic signed [CORDIC_W-1:0] z0_reg     [4];
    logic signed [CORDIC_W-1:0] rot_x      [4];
    logic signed [CORDIC_W-1:0] rot_y      [4];

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        localparam int          SH  = (l < 2) ? SH_LAT : SH_HALF;
        localparam logic [65:0] RND = (l < 2) ? RND_LAT : RND_HALF;
        logic [65:0] sum;

        assign sum = 66'(rad_lo_reg[l]) + (66'(rad_hi_reg[l]) << 17) + RND;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[l]    <= mag_in[l];
                rad_lo_reg[l] <= mag_reg[l] * D_LO;
                rad_hi_reg[l] <= mag_reg[l] * D_HI;
                z0_reg[l]     <= CORDIC_W'(sum >> SH);
            end
        end

        hvd_cordic #(
            .ITER      (N),
            .VECTORING (1'b0)
        ) u_rot (
            .clk   (clk),
            .en    (en),
            .x_in  (GAIN_INV),
            .y_in  ('0),
            .z_in  (z0_reg[l]),
            .x_out (rot_x[l]),
            .y_out (rot_y[l]),
            .z_out ()
        );
    end

    // haversine term
    logic [UNIT_W-1:0] m1_reg, m2_reg, m3_reg, m1d_reg, m4_reg, a_reg;
    logic [UNIT_W:0]   a_sum;

    assign a_sum = (UNIT_W + 1)'(m1d_reg) + (UNIT_W + 1)'(m4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= pmul(clamp_unit(rot_y[2]), clamp_unit(rot_y[2]));
            m2_reg  <= pmul(clamp_unit(rot_x[0]), clamp_unit(rot_x[1]));
            m3_reg  <= pmul(clamp_unit(rot_y[3]), clamp_unit(rot_y[3]));
            m1d_reg <= m1_reg;
            m4_reg  <= pmul(m2_reg, m3_reg);
            a_reg   <= (a_sum > (UNIT_W + 1)'(ONE_Q30)) ? ONE_Q30 : UNIT_W'(a_sum);
        end
    end

    // roots and central angle
    logic [UNIT_W-1:0]          root_a, root_c;
    logic [UNIT_W-1:0]          comp_a;
    logic signed [CORDIC_W-1:0] vec_z;

    assign comp_a = ONE_Q30 - a_reg;

    hvd_isqrt u_sqrt_a (
        .clk  (clk),
        .en   (en),
        .v_in ({a_reg, 30'd0}),
        .root (root_a)
    );

    hvd_isqrt u_sqrt_c (
        .clk  (clk),
        .en   (en),
        .v_in ({comp_a, 30'd0}),
        .root (root_c)
    );

    hvd_cordic #(
        .ITER      (N),
        .VECTORING (1'b1)
    ) u_vec (
        .clk   (clk),
        .en    (en),
        .x_in  (CORDIC_W'(root_c)),
        .y_in  (CORDIC_W'(root_a)),
        .z_in  ('0),
        .x_out (),
        .y_out (),
        .z_out (vec_z)
    );

    // distance
    logic signed [CORDIC_W:0]      ang2;
    logic [ANG_W-1:0]              ang;
    logic [RADIUS_W+ANG_W-1:0]     prod_reg;
    logic [RADIUS_W+ANG_W:0]       prod_rnd;
    logic [DIST_W-1:0]             dist_reg;
    logic                          rerr_reg;

    assign ang2 = {vec_z, 1'b0};

    always_comb
    begin
        if (ang2[CORDIC_W])
        begin
            ang = '0;
        end
        else if ((CORDIC_W + 1)'(ang2) > (CORDIC_W + 1)'(PI_Q30))
        begin
            ang = PI_Q30;
        end
        else
        begin
            ang = ANG_W'(ang2);
        end
    end

    assign prod_rnd = (RADIUS_W + ANG_W + 1)'(prod_reg) + (RADIUS_W + ANG_W + 1)'(1 << 29);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= radius_reg * ang;
            dist_reg <= err_reg[DEPTH-1] ? '0 : DIST_W'(prod_rnd >> 30);
            rerr_reg <= err_reg[DEPTH-1];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.distance_m  = dist_reg;
    assign rsp.range_error = rerr_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.range_error |-> rsp.distance_m == '0)
        else $error("range error with nonzero distance");

    a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.distance_m <= DIST_W'(52707179))
        else $error("distance beyond half circumference");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(vld_reg[DEPTH-1]))
        else $error("response without a request in the last stage");

endmodule
